FILE: rtl/core/msfa_pkg.sv
// Shared types and constants of the multichannel sample frame aligner.
package msfa_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE   = 2'd1;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [2:0]         channel;
        logic signed [31:0] sample;
        logic [31:0]        timestamp;
    } in_word_t;

    typedef struct packed {
        logic               is_marker;
        logic [2:0]         channel_res;
        logic signed [31:0] sample_res;
        logic [31:0]        frame_time;
        logic [4:0]         frames_in_batch;
        logic               last_of_frame;
        logic               last_of_batch;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_EMIT,
        ST_MARK
    } msfa_state_t;

    typedef struct packed {
        logic load_in;
        logic push;
        logic frame_start;
        logic rd_first;
        logic advance;
        logic emit_sample;
        logic emit_marker;
    } dp_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic batch_pending;
        logic frame_ok;
        logic last_chan;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: rtl/core/msfa_dp.sv
// Datapath: config registers, per-channel FIFOs in one sample store, batch count, output word.
module msfa_dp
    import msfa_pkg::*;
#(
    parameter int CHANNELS   = 8,
    parameter int FIFO_DEPTH = 32,
    parameter int MAX_BATCH  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_word_t              item,
    input  logic                  result_stall,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    output logic                  result_valid,
    output out_word_t             result
);

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW    = $clog2(FIFO_DEPTH);
    localparam int NW    = $clog2(FIFO_DEPTH + 1);
    localparam int DEPTH = CHANNELS * FIFO_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = $clog2(MAX_BATCH + 1);

    logic [7:0]          mask_reg;
    logic [4:0]          bsize_reg;
    logic [PW-1:0]       rp_reg   [CHANNELS];
    logic [PW-1:0]       wp_reg   [CHANNELS];
    logic [NW-1:0]       fill_reg [CHANNELS];
    logic [BW-1:0]       bfc_reg;
    logic [BW-1:0]       bfc_next;
    logic [BW-1:0]       fib_reg;
    logic                lob_reg;
    logic [CW-1:0]       idx_reg;
    logic [31:0]         time_reg;
    logic [31:0]         rdata_reg;
    logic                ren_reg;
    logic                rv_reg;
    logic                rv_next;
    out_word_t           res_reg;
    out_word_t           res_next;
    logic [31:0]         mem [DEPTH];

    logic [CHANNELS-1:0] en;
    logic [CHANNELS-1:0] rdy;
    logic [4:0]          ch_ext;
    logic [CW-1:0]       ch_idx;
    logic                push_ok;
    logic [AW-1:0]       wr_addr;
    logic                rd_en;
    logic [CW-1:0]       idx_p1;
    logic [CW-1:0]       rd_ch;
    logic [AW-1:0]       rd_addr;
    logic [BW-1:0]       eff;
    logic [BW-1:0]       cnt1;
    logic                lob;
    logic [4:0]          idx_ext;
    logic [7:0]          fib_ext;
    logic [7:0]          bfc_ext;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            en[c]  = (c < 8) ? mask_reg[3'(c)] : 1'b0;
            rdy[c] = !en[c] || (fill_reg[c] != '0);
        end
    end

    assign ch_ext  = {2'b00, item.channel};
    assign ch_idx  = ch_ext[CW-1:0];
    assign push_ok = cmd.push && (ch_ext < 5'(CHANNELS)) && en[ch_idx]
                     && (fill_reg[ch_idx] != NW'(FIFO_DEPTH));
    assign wr_addr = AW'(32'(ch_idx) * FIFO_DEPTH + 32'(wp_reg[ch_idx]));

    assign rd_en   = cmd.rd_first || cmd.advance;
    assign idx_p1  = idx_reg + 1'b1;
    assign rd_ch   = cmd.advance ? idx_p1 : idx_reg;
    assign rd_addr = AW'(32'(rd_ch) * FIFO_DEPTH + 32'(rp_reg[rd_ch]));

    // batch size 0 acts as 1, above MAX_BATCH saturates
    always_comb
    begin
        priority if (bsize_reg == 5'd0)
            eff = BW'(1);
        else if (32'(bsize_reg) > MAX_BATCH)
            eff = BW'(MAX_BATCH);
        else
            eff = BW'(bsize_reg);
    end

    assign cnt1 = bfc_reg + 1'b1;
    assign lob  = (cnt1 >= eff);

    always_comb
    begin
        bfc_next = bfc_reg;
        if (cmd.frame_start)
            bfc_next = lob ? '0 : cnt1;
        else if (cmd.emit_marker)
            bfc_next = '0;
    end

    assign idx_ext = 5'(idx_reg);
    assign fib_ext = 8'(fib_reg);
    assign bfc_ext = 8'(bfc_reg);

    always_comb
    begin
        res_next = res_reg;
        rv_next  = rv_reg && result_stall;
        if (cmd.emit_sample)
        begin
            rv_next                  = 1'b1;
            res_next.is_marker       = 1'b0;
            res_next.channel_res     = idx_ext[2:0];
            res_next.sample_res      = ren_reg ? rdata_reg : 32'd0;
            res_next.frame_time      = time_reg;
            res_next.frames_in_batch = fib_ext[4:0];
            res_next.last_of_frame   = (idx_reg == CW'(CHANNELS - 1));
            res_next.last_of_batch   = lob_reg;
        end
        else if (cmd.emit_marker)
        begin
            rv_next                  = 1'b1;
            res_next.is_marker       = 1'b1;
            res_next.channel_res     = 3'd0;
            res_next.sample_res      = 32'sd0;
            res_next.frame_time      = time_reg;
            res_next.frames_in_batch = bfc_ext[4:0];
            res_next.last_of_frame   = 1'b1;
            res_next.last_of_batch   = 1'b1;
        end
    end

    assign sts.is_flush      = (item.action == ACT_FLUSH);
    assign sts.batch_pending = (bfc_reg != '0);
    assign sts.frame_ok      = (|en) && (&rdy);
    assign sts.last_chan     = (idx_reg == CW'(CHANNELS - 1));
    assign sts.out_free      = !rv_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= 8'd1;
            bsize_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_CHANNEL_MASK)
                mask_reg <= cfg_data;
            else if (cfg_index == REG_BATCH_SIZE)
                bsize_reg <= cfg_data[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                rp_reg[c]   <= '0;
                wp_reg[c]   <= '0;
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (push_ok && (ch_idx == CW'(c)))
                begin
                    wp_reg[c]   <= (wp_reg[c] == PW'(FIFO_DEPTH - 1)) ? '0 : wp_reg[c] + 1'b1;
                    fill_reg[c] <= fill_reg[c] + 1'b1;
                end
                if (rd_en && (rd_ch == CW'(c)) && en[c])
                begin
                    rp_reg[c]   <= (rp_reg[c] == PW'(FIFO_DEPTH - 1)) ? '0 : rp_reg[c] + 1'b1;
                    fill_reg[c] <= fill_reg[c] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bfc_reg <= '0;
            rv_reg  <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            bfc_reg <= bfc_next;
            rv_reg  <= rv_next;
            if (cmd.frame_start)
                idx_reg <= '0;
            else if (cmd.advance)
                idx_reg <= idx_p1;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.load_in)
            time_reg <= item.timestamp;
        if (cmd.frame_start)
        begin
            fib_reg <= cnt1;
            lob_reg <= lob;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem[wr_addr] <= item.sample;
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            ren_reg   <= en[rd_ch];
        end
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

FILE: rtl/core/msfa_ctrl.sv
// Controller: sequences word intake, frame check, per-channel readout and flush marker.
module msfa_ctrl
    import msfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  dp_sts_t sts,
    output logic    item_stall,
    output dp_cmd_t cmd
);

    msfa_state_t state_reg;
    msfa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (sts.is_flush)
                        state_next = sts.batch_pending ? ST_MARK : ST_IDLE;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
                state_next = sts.frame_ok ? ST_READ : ST_IDLE;
            ST_READ:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (sts.out_free && sts.last_chan)
                    state_next = ST_IDLE;
            end
            ST_MARK:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.load_in = item_valid;
                cmd.push    = item_valid && !sts.is_flush;
            end
            ST_CHECK:
                cmd.frame_start = sts.frame_ok;
            ST_READ:
                cmd.rd_first = 1'b1;
            ST_EMIT:
            begin
                cmd.emit_sample = sts.out_free;
                cmd.advance     = sts.out_free && !sts.last_chan;
            end
            ST_MARK:
                cmd.emit_marker = sts.out_free;
            default:
                item_stall = 1'b1;
        endcase
    end

endmodule

FILE: rtl/core/multichannel_sample_frame_aligner.sv
// Top level of the multichannel sample frame aligner.
//
//  channel | signals                            | word
//  --------+------------------------------------+--------------------------
//  item    | item_valid, item_stall, item       | in_word_t
//  result  | result_valid, result_stall, result | out_word_t
//  config  | cfg_we, cfg_index, cfg_data        | channel_mask, batch_size
//
// One item at a time. A sample word is pushed, then the frame check runs; when it
// completes a frame, one word goes out per channel (one sample store read per
// channel per cycle while result_stall is low). A flush sends a marker only when a batch is pending.
// result_stall holds the readout in place; no word is lost.
// rst_n clears pointers and counts and sets config to mask 1, batch size 1; the sample store is not cleared.
module multichannel_sample_frame_aligner
    import msfa_pkg::*;
#(
    parameter int CHANNELS   = 8,
    parameter int FIFO_DEPTH = 32,
    parameter int MAX_BATCH  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  in_word_t              item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_word_t             result
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    msfa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .sts        (sts),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    msfa_dp #(
        .CHANNELS   (CHANNELS),
        .FIFO_DEPTH (FIFO_DEPTH),
        .MAX_BATCH  (MAX_BATCH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: rtl/core/msfa_chk.sv
// Port-level checker for the frame aligner, bound to the top level.
module msfa_chk
    import msfa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_stall,
    input in_word_t  item,
    input logic      result_valid,
    input logic      result_stall,
    input out_word_t result
);

    // stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_marker |->
            result.last_of_frame && result.last_of_batch
            && (result.channel_res == 3'd0) && (result.sample_res == 32'sd0))
        else $error("malformed flush marker");

    // a sample word always goes through the frame check
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.action == ACT_SAMPLE) |=> item_stall)
        else $error("sample word accepted back to back");

    // frame readout runs without gaps, channel by channel
    a_frame_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.is_marker && !result.last_of_frame
        |=> result_valid && !result.is_marker
            && (result.channel_res == $past(result.channel_res) + 3'd1)
            && (result.frame_time == $past(result.frame_time)))
        else $error("gap or misorder inside a frame");

endmodule

bind multichannel_sample_frame_aligner msfa_chk u_msfa_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

FILE: test/msfa_frame_checker.sv
// Watches the frame aligner's channels, predicts every result word and compares it.
module msfa_frame_checker
    import msfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    input  logic                  item_stall,
    input  in_word_t              item,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  out_word_t             result,
    output int                    pending_words,
    output int                    mismatches,
    output int                    frames_checked,
    output int                    markers_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS   = 8;
    localparam int FIFO_DEPTH = 32;
    localparam int MAX_BATCH  = 16;

    logic signed [31:0] chan_fifo [CHANNELS][FIFO_DEPTH];
    int unsigned        rd_ptr [CHANNELS];
    int unsigned        wr_ptr [CHANNELS];
    int unsigned        fill [CHANNELS];
    int unsigned        batch_count;
    logic [7:0]         mask_reg;
    logic [4:0]         batch_reg;
    out_word_t          frame_words [$];

    function automatic string show(input out_word_t r);
        return $sformatf("marker=%0b ch=%0d sample=%0d time=%h frame=%0d lof=%0b lob=%0b",
                         r.is_marker, r.channel_res, r.sample_res, r.frame_time,
                         r.frames_in_batch, r.last_of_frame, r.last_of_batch);
    endfunction

    task automatic align_word(input in_word_t w);
        out_word_t   r;
        bit          ready;
        bit          closes;
        int unsigned limit;
        if (w.action == ACT_FLUSH) begin
            if (batch_count != 0) begin
                r                 = '0;
                r.is_marker       = 1'b1;
                r.frame_time      = w.timestamp;
                r.frames_in_batch = 5'(batch_count);
                r.last_of_frame   = 1'b1;
                r.last_of_batch   = 1'b1;
                frame_words.push_back(r);
                batch_count = 0;
            end
        end
        else begin
            if (mask_reg[w.channel] && fill[w.channel] < FIFO_DEPTH) begin
                chan_fifo[w.channel][wr_ptr[w.channel]] = w.sample;
                wr_ptr[w.channel] = (wr_ptr[w.channel] + 1) % FIFO_DEPTH;
                fill[w.channel]++;
            end
            ready = (mask_reg != 0);
            for (int c = 0; c < CHANNELS; c++)
                if (mask_reg[c] && fill[c] == 0)
                    ready = 1'b0;
            if (ready) begin
                limit = (batch_reg == 0) ? 1 : (batch_reg > MAX_BATCH) ? MAX_BATCH : batch_reg;
                batch_count++;
                closes = (batch_count >= limit);
                for (int c = 0; c < CHANNELS; c++) begin
                    r             = '0;
                    r.channel_res = 3'(c);
                    if (mask_reg[c]) begin
                        r.sample_res = chan_fifo[c][rd_ptr[c]];
                        rd_ptr[c] = (rd_ptr[c] + 1) % FIFO_DEPTH;
                        fill[c]--;
                    end
                    r.frame_time      = w.timestamp;
                    r.frames_in_batch = 5'(batch_count);
                    r.last_of_frame   = (c == CHANNELS - 1);
                    r.last_of_batch   = closes;
                    frame_words.push_back(r);
                end
                if (closes)
                    batch_count = 0;
            end
        end
    endtask

    always @(posedge clk)
    begin : watch
        out_word_t want;
        if (!rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                rd_ptr[c] = 0;
                wr_ptr[c] = 0;
                fill[c]   = 0;
            end
            batch_count = 0;
            mask_reg    = 8'd1;
            batch_reg   = 5'd1;
            frame_words.delete();
            mismatches      = 0;
            frames_checked  = 0;
            markers_checked = 0;
        end
        else begin
            if (result_valid && !result_stall) begin
                if (frame_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word: %s", $time, show(result));
                end
                else begin
                    want = frame_words.pop_front();
                    if (result !== want) begin
                        mismatches++;
                        $display("%0t: mismatch, expected %s", $time, show(want));
                        $display("%0t:           actual   %s", $time, show(result));
                    end
                    else if (want.is_marker)
                        markers_checked++;
                    else if (want.last_of_frame)
                        frames_checked++;
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHANNEL_MASK: mask_reg  = cfg_data;
                    REG_BATCH_SIZE:   batch_reg = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
                align_word(item);
        end
        pending_words = frame_words.size();
    end

endmodule

FILE: test/multichannel_sample_frame_aligner_test.sv
// Stimulus and verdict for the multichannel sample frame aligner.
module multichannel_sample_frame_aligner_test;
    timeunit 1ns;
    timeprecision 1ps;

    import msfa_pkg::*;

    localparam int PHASES        = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int BURST_LEN     = 36;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

    localparam logic [7:0] PHASE_MASK [PHASES] =
        '{8'hFF, 8'h01, 8'h80, 8'h5A, 8'h00, 8'h0F, 8'hA5, 8'hFF};
    localparam logic [7:0] PHASE_BATCH [PHASES] =
        '{8'd16, 8'd1, 8'd0, 8'd31, 8'd4, 8'hE2, 8'd7, 8'd1};
    localparam int PHASE_WORDS [PHASES] = '{40, 40, 40, 40, 8, 40, 40, 40};

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    in_word_t              item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    out_word_t             result;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int words_sent = 0;
    int settings_used = 0;
    int pending_words;
    int mismatches;
    int frames_checked;
    int markers_checked;

    multichannel_sample_frame_aligner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    msfa_frame_checker frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .pending_words   (pending_words),
        .mismatches      (mismatches),
        .frames_checked  (frames_checked),
        .markers_checked (markers_checked)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic in_word_t word_of(input logic act, input logic [2:0] ch,
                                         input logic signed [31:0] val,
                                         input logic [31:0] ts);
        in_word_t w;
        w.action    = act;
        w.channel   = ch;
        w.sample    = val;
        w.timestamp = ts;
        return w;
    endfunction

    function automatic logic [2:0] enabled_channel(input logic [7:0] m);
        logic [2:0] c;
        c = 3'($urandom_range(0, 7));
        while (!m[c])
            c = c + 3'd1;
        return c;
    endfunction

    function automatic in_word_t random_word(input logic [7:0] m);
        int         roll;
        logic [2:0] ch;
        roll = $urandom_range(0, 99);
        ch = (roll < 15 || m == 0) ? 3'($urandom_range(0, 7)) : enabled_channel(m);
        return word_of((roll < 7) ? ACT_FLUSH : ACT_SAMPLE, ch, $urandom, $urandom);
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 81; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 81; end
            default:       begin send_idle_pct = 11; stall_pct = 11; end
        endcase
    endtask

    task automatic send_word(input in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic hold_until_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
    endtask

    // drain, then give a word with no result time to leave the block
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [7:0] mask_v, input logic [7:0] batch_v);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CHANNEL_MASK;
        cfg_data  <= mask_v;
        @(posedge clk);
        cfg_index <= REG_BATCH_SIZE;
        cfg_data  <= batch_v;
        @(posedge clk);
        cfg_index <= ($urandom_range(0, 1) != 0) ? REG_UNUSED_HI : REG_UNUSED_LO;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        logic [7:0] mask_v;
        logic [7:0] batch_v;
        logic [2:0] burst_ch;
        int         count;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: channel 0 alone, batches of one
        send_word(word_of(ACT_FLUSH, 3'd0, 32'sd0, 32'h0));
        send_word(word_of(ACT_SAMPLE, 3'd0, 32'sh8000_0000, 32'h0));
        send_word(word_of(ACT_SAMPLE, 3'd0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF));
        send_word(word_of(ACT_SAMPLE, 3'd5, -32'sd1, 32'h1));
        send_word(word_of(ACT_FLUSH, 3'd7, -32'sd1, 32'hFFFF_FFFF));
        settle();

        write_settings(8'hFF, 8'd3);
        for (int c = 0; c < 8; c++)
            send_word(word_of(ACT_SAMPLE, 3'(c), c[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000,
                              32'(c)));
        send_word(word_of(ACT_FLUSH, 3'd0, 32'sd0, 32'd100));
        send_word(word_of(ACT_FLUSH, 3'd0, 32'sd0, 32'd101));
        settle();

        // empty mask, zero batch
        write_settings(8'h00, 8'd0);
        send_word(word_of(ACT_SAMPLE, 3'd0, 32'sd5, 32'd200));
        send_word(word_of(ACT_SAMPLE, 3'd7, 32'sd6, 32'd201));
        send_word(word_of(ACT_FLUSH, 3'd0, 32'sd0, 32'd202));
        settle();

        // batch above the maximum saturates
        write_settings(8'h81, 8'd31);
        send_word(word_of(ACT_SAMPLE, 3'd7, -32'sd7, 32'd300));
        send_word(word_of(ACT_SAMPLE, 3'd0, 32'sd8, 32'd301));
        send_word(word_of(ACT_FLUSH, 3'd0, 32'sd0, 32'd302));
        settle();

        for (int p = 0; p < PHASES; p++) begin
            mask_v  = PHASE_MASK[p];
            batch_v = PHASE_BATCH[p];
            if (p == PHASES - 1) begin
                mask_v  = 8'($urandom_range(1, 255));
                batch_v = 8'($urandom_range(1, 16));
            end
            write_settings(mask_v, batch_v);
            set_idling(idle_mode_t'(p % 4));
            count = 0;
            // overfill one FIFO so samples get dropped
            if (p % 3 == 0 && $countones(mask_v) > 1) begin
                burst_ch = enabled_channel(mask_v);
                repeat (BURST_LEN) begin
                    send_word(word_of(ACT_SAMPLE, burst_ch, $urandom, $urandom));
                    count++;
                end
            end
            while (count < PHASE_WORDS[p]) begin
                if ($urandom_range(0, 99) < 3)
                    hold_until_drained();
                send_word(random_word(mask_v));
                count++;
            end
            settle();
        end

        $display("Sent %0d words under %0d register settings, all idling modes.",
                 words_sent, settings_used);
        $display("Checked %0d frames and %0d flush markers.", frames_checked, markers_checked);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
